// ===== rtl/fsr_pkg.sv =====
// Shared types and character constants for the FASTA record scanner.
`timescale 1ns / 1ps

package fsr_pkg;

   localparam int OUT_BITS = 32;

   localparam logic [7:0] CHAR_GT   = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_NL   = 8'h0A;  // newline
   localparam logic [7:0] CHAR_LC_C = 8'h63;  // 'c'
   localparam logic [7:0] CHAR_UC_C = 8'h43;  // 'C'
   localparam logic [7:0] CHAR_LC_G = 8'h67;  // 'g'
   localparam logic [7:0] CHAR_UC_G = 8'h47;  // 'G'

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] record_index;
      logic [OUT_BITS-1:0] header_start;
      logic [OUT_BITS-1:0] header_end;
      logic [OUT_BITS-1:0] sequence_end;
      logic [OUT_BITS-1:0] line_length;
      logic [OUT_BITS-1:0] base_count;
      logic [OUT_BITS-1:0] gc_count;
      logic [OUT_BITS-1:0] longest_bases;
      logic                is_last;
   } rsp_type;

endpackage

// ===== rtl/fasta_record_scanner.sv =====
// Top level of the FASTA record scanner: input register, step core, result register.
`timescale 1ns / 1ps

// The scanner takes one FASTA text byte per beat and keeps up with one beat every
// clock cycle while no finished result waits on rsp_ready. A byte is captured in an
// input register, goes through the scanner step when the result register is free
// and, when it closes a record ('>' after an open record, or an end-of-input beat),
// leaves a result beat in the output register. The input register lets a new
// byte be taken while a finished result still waits on rsp_ready. An end-of-input
// beat reports the open record, if any, and returns all counters to zero so that the
// next byte starts a new stream. Counters saturate at 2**COUNT_BITS - 1 and the
// result fields carry their low 32 bits.
module fasta_record_scanner #(
   parameter int COUNT_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fsr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fsr_pkg::rsp_type rsp_data
);

   logic             in_valid_ff, in_valid_in;
   fsr_pkg::req_type in_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   fsr_pkg::rsp_type rsp_data_ff;
   logic             step_en;
   fsr_pkg::rsp_type step_result;
   logic             step_hit;

   // A byte steps only when the result register is free to take what it produces.
   assign step_en   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;

   fsr_core #(
      .COUNT_BITS(COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .item      (in_data_ff),
      .result    (step_result),
      .result_hit(step_hit)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         rsp_valid_in = step_hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step_en && step_hit) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/fsr_core.sv =====
// Scanner state registers and the combinational byte step that updates them.
`timescale 1ns / 1ps

module fsr_core #(
   parameter int COUNT_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  fsr_pkg::req_type item,
   output fsr_pkg::rsp_type result,
   output logic             result_hit
);

   logic [COUNT_BITS-1:0] offset_ff, offset_in;
   logic                  in_header_ff, in_header_in;
   logic                  seen_ff, seen_in;
   logic [COUNT_BITS-1:0] index_ff, index_in;
   logic [COUNT_BITS-1:0] hdr_start_ff, hdr_start_in;
   logic [COUNT_BITS-1:0] hdr_end_ff, hdr_end_in;
   logic [COUNT_BITS-1:0] length_ff, length_in;
   logic [COUNT_BITS-1:0] bases_ff, bases_in;
   logic [COUNT_BITS-1:0] gc_ff, gc_in;
   logic [COUNT_BITS-1:0] longest_ff, longest_in;

   logic [COUNT_BITS-1:0] longest_now;
   logic                  is_gt;
   logic                  is_nl;
   logic                  is_gc;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (&v) ? v : v + COUNT_BITS'(1);
   endfunction

   function automatic logic [fsr_pkg::OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[fsr_pkg::OUT_BITS-1:0];
   endfunction

   assign is_gt = (item.byte_value == fsr_pkg::CHAR_GT);
   assign is_nl = (item.byte_value == fsr_pkg::CHAR_NL);
   assign is_gc = item.byte_value inside {fsr_pkg::CHAR_LC_C, fsr_pkg::CHAR_UC_C,
                                          fsr_pkg::CHAR_LC_G, fsr_pkg::CHAR_UC_G};

   // The running maximum includes the record being reported.
   assign longest_now = (bases_ff > longest_ff) ? bases_ff : longest_ff;

   assign result_hit = seen_ff && (item.end_of_input || is_gt);

   always_comb begin
      result.record_index  = to_out(index_ff);
      result.header_start  = to_out(hdr_start_ff);
      result.header_end    = to_out(hdr_end_ff);
      result.sequence_end  = to_out(offset_ff - COUNT_BITS'(1));
      result.line_length   = to_out(length_ff);
      result.base_count    = to_out(bases_ff);
      result.gc_count      = to_out(gc_ff);
      result.longest_bases = to_out(longest_now);
      result.is_last       = item.end_of_input;
   end

   always_comb begin
      offset_in    = offset_ff;
      in_header_in = in_header_ff;
      seen_in      = seen_ff;
      index_in     = index_ff;
      hdr_start_in = hdr_start_ff;
      hdr_end_in   = hdr_end_ff;
      length_in    = length_ff;
      bases_in     = bases_ff;
      gc_in        = gc_ff;
      longest_in   = longest_ff;
      if (item.end_of_input) begin
         // End of stream returns everything to its reset values.
         offset_in    = '0;
         in_header_in = 1'b0;
         seen_in      = 1'b0;
         index_in     = '0;
         hdr_start_in = '0;
         hdr_end_in   = '0;
         length_in    = '0;
         bases_in     = '0;
         gc_in        = '0;
         longest_in   = '0;
      end else begin
         offset_in = sat_inc(offset_ff);
         if (is_gt) begin
            if (seen_ff) begin
               longest_in = longest_now;
               index_in   = sat_inc(index_ff);
               length_in  = '0;
            end
            seen_in      = 1'b1;
            hdr_start_in = offset_ff;
            hdr_end_in   = '0;
            in_header_in = 1'b1;
         end else if (in_header_ff && is_nl) begin
            in_header_in = 1'b0;
            hdr_end_in   = offset_ff;
            length_in    = '0;
            bases_in     = '0;
            gc_in        = '0;
         end else begin
            if (!is_nl) begin
               bases_in = sat_inc(bases_ff);
               if (is_gc) begin
                  gc_in = sat_inc(gc_ff);
               end
            end
            length_in = sat_inc(length_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         in_header_ff <= 1'b0;
         seen_ff      <= 1'b0;
         index_ff     <= '0;
         hdr_start_ff <= '0;
         hdr_end_ff   <= '0;
         length_ff    <= '0;
         bases_ff     <= '0;
         gc_ff        <= '0;
         longest_ff   <= '0;
      end else if (step_en) begin
         offset_ff    <= offset_in;
         in_header_ff <= in_header_in;
         seen_ff      <= seen_in;
         index_ff     <= index_in;
         hdr_start_ff <= hdr_start_in;
         hdr_end_ff   <= hdr_end_in;
         length_ff    <= length_in;
         bases_ff     <= bases_in;
         gc_ff        <= gc_in;
         longest_ff   <= longest_in;
      end
   end

endmodule
